// ----- hw/rtl/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg: shared constants and types of the linear segment envelope
// Gain format, register indexes, reset values and the ramp unit result bundle.
// ----------------------------------------------------------------------------
package lse_pkg;

   localparam int TIME_BITS_DEF   = 24;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int GAIN_BITS = 16;
   localparam int GAIN_FRAC = 14;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_START_TIME = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_TIME   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_GAIN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_GAIN   = 2'd3;

   localparam int unsigned START_TIME_RESET = 0;
   localparam int unsigned END_TIME_RESET   = 48000;
   localparam logic [GAIN_BITS-1:0] START_GAIN_RESET = 16'h4000;
   localparam logic [GAIN_BITS-1:0] END_GAIN_RESET   = 16'h0000;

   typedef struct packed {
      logic                 done;
      logic [GAIN_BITS-1:0] quot;
   } ramp_rsp_type;

endpackage

// ----- hw/rtl/lse_ramp.sv -----
// ----------------------------------------------------------------------------
// lse_ramp: serial gain step unit
// Computes floor(offset * mag / span) with a bit-serial shift-add multiply
// followed by a bit-serial restoring divide sharing one shift register.
// ----------------------------------------------------------------------------
module lse_ramp #(
   parameter int TIME_BITS = lse_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [TIME_BITS-1:0]           offset,
   input  logic [TIME_BITS-1:0]           span,
   input  logic [lse_pkg::GAIN_BITS-1:0]  mag,
   output lse_pkg::ramp_rsp_type          rsp
);

   localparam int GB       = lse_pkg::GAIN_BITS;
   localparam int PW       = TIME_BITS + GB + 1;
   localparam int CNT_MAX  = (TIME_BITS > GB) ? TIME_BITS : GB;
   localparam int CNT_BITS = $clog2(CNT_MAX + 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]        p_ff, p_in;
   logic [GB-1:0]        mag_ff, mag_in;
   logic [TIME_BITS-1:0] span_ff, span_in;
   logic                 done_ff, done_in;

   logic [GB:0]          mul_sum;
   logic [PW-1:0]        mul_next;
   logic [TIME_BITS:0]   div_shift;
   logic [TIME_BITS+1:0] div_trial;
   logic                 div_qbit;
   logic [TIME_BITS-1:0] div_rem;
   logic [PW-1:0]        div_next;

   always_comb begin
      mul_sum  = {1'b0, p_ff[PW-2:TIME_BITS]} + (p_ff[0] ? {1'b0, mag_ff} : '0);
      mul_next = {1'b0, mul_sum, p_ff[TIME_BITS-1:1]};

      div_shift = {p_ff[TIME_BITS+GB-1:GB], p_ff[GB-1]};
      div_trial = {1'b0, div_shift} - {2'b00, span_ff};
      div_qbit  = ~div_trial[TIME_BITS+1];
      div_rem   = div_qbit ? div_trial[TIME_BITS-1:0] : div_shift[TIME_BITS-1:0];
      div_next  = {1'b0, div_rem, p_ff[GB-2:0], div_qbit};
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      p_in     = p_ff;
      mag_in   = mag_ff;
      span_in  = span_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (go) begin
               phase_in = PH_MUL;
               cnt_in   = CNT_BITS'(TIME_BITS);
               p_in     = {{(GB+1){1'b0}}, offset};
               mag_in   = mag;
               span_in  = span;
            end
         end
         PH_MUL: begin
            p_in = mul_next;
            if (cnt_ff == CNT_BITS'(1)) begin
               phase_in = PH_DIV;
               cnt_in   = CNT_BITS'(GB);
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         PH_DIV: begin
            p_in = div_next;
            if (cnt_ff == CNT_BITS'(1)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      mag_ff  <= mag_in;
      span_ff <= span_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = p_ff[GB-1:0];

endmodule

// ----- hw/rtl/linear_segment_envelope.sv -----
// ----------------------------------------------------------------------------
// linear_segment_envelope: linear gain ramp over an audio stream
// One transfer on the req_ channel is one audio tick; each yields one
// transfer on the rsp_ channel with the scaled sample and the alive flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries a signed sample and a restart flag (restart zeroes the age
//   counter before the tick). rsp_ returns the sample scaled by a gain that
//   moves linearly from start_gain to end_gain between start_time and
//   end_time, zero outside that window, with alive low once age passes
//   end_time. csr_ writes registers 0..3 (start_time, end_time, start_gain,
//   end_gain); write them only while no tick is in flight.
// Sequence:
//   A tick inside the ramp passes through the bit-serial multiply and the
//   bit-serial divide in the ramp unit, then the gain sum register, the
//   sample multiply register and the saturating output register before
//   rsp_valid. A tick outside the ramp goes straight to the output
//   register. One tick is worked on at a time; req_stall is high while it
//   is, so the next tick is not accepted until the current one has reached
//   the output register.
// Reset and stall:
//   Reset clears the age counter, the registers to their defaults and drops
//   rsp_valid. A held result stays on rsp_ while rsp_stall is high; the
//   next tick may be accepted meanwhile and waits for the output register.
// ----------------------------------------------------------------------------
module linear_segment_envelope #(
   parameter int TIME_BITS   = lse_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = lse_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic                                req_restart,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_alive,

   input  logic                                csr_wr_en,
   input  logic [lse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [((TIME_BITS > lse_pkg::GAIN_BITS) ? TIME_BITS
                  : lse_pkg::GAIN_BITS)-1:0]   csr_data
);

   localparam int GB       = lse_pkg::GAIN_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + GB;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RAMP = 2'd1;
   localparam logic [1:0] S_MULT = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [TIME_BITS-1:0] start_time_ff, start_time_in;
   logic [TIME_BITS-1:0] end_time_ff, end_time_in;
   logic [GB-1:0]        start_gain_ff, start_gain_in;
   logic [GB-1:0]        end_gain_ff, end_gain_in;

   logic [1:0]           state_ff, state_in;
   logic [TIME_BITS:0]   age_ff, age_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                 rsp_alive_ff, rsp_alive_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                 alive_ff, alive_in;
   logic                 ramp_ff, ramp_in;
   logic                 gneg_ff, gneg_in;
   logic                 zspan_ff, zspan_in;
   logic [GB-1:0]        gain_ff, gain_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   logic                 req_xfer;
   logic [TIME_BITS:0]   age_eff;
   logic                 dead;
   logic                 in_ramp;
   logic [TIME_BITS-1:0] offset;
   logic [TIME_BITS-1:0] span;
   logic [GB:0]          gdiff;
   logic [GB:0]          gmag;
   logic                 ramp_go;
   lse_pkg::ramp_rsp_type ramp_rsp;

   logic [GB:0]          qext;
   logic [GB:0]          gsum;
   logic [SAMPLE_BITS+1:0] scaled;
   logic [2:0]           scaled_top;
   logic [SAMPLE_BITS-1:0] sat_val;
   logic                 out_free;

   // register file
   always_comb begin
      start_time_in = start_time_ff;
      end_time_in   = end_time_ff;
      start_gain_in = start_gain_ff;
      end_gain_in   = end_gain_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lse_pkg::REG_START_TIME: start_time_in = csr_data[TIME_BITS-1:0];
            lse_pkg::REG_END_TIME:   end_time_in   = csr_data[TIME_BITS-1:0];
            lse_pkg::REG_START_GAIN: start_gain_in = csr_data[GB-1:0];
            lse_pkg::REG_END_GAIN:   end_gain_in   = csr_data[GB-1:0];
            default: ;
         endcase
      end
   end

   // tick decode
   always_comb begin
      req_xfer = req_valid && (state_ff == S_IDLE);
      age_eff  = req_restart ? '0 : age_ff;
      dead     = age_eff > {1'b0, end_time_ff};
      in_ramp  = !dead && (age_eff >= {1'b0, start_time_ff});
      offset   = age_eff[TIME_BITS-1:0] - start_time_ff;
      span     = end_time_ff - start_time_ff;
      gdiff    = {end_gain_ff[GB-1], end_gain_ff} - {start_gain_ff[GB-1], start_gain_ff};
      gmag     = gdiff[GB] ? (~gdiff + (GB+1)'(1)) : gdiff;
      ramp_go  = req_xfer && in_ramp;
   end

   lse_ramp #(
      .TIME_BITS (TIME_BITS)
   ) u_ramp (
      .clock  (clock),
      .reset  (reset),
      .go     (ramp_go),
      .offset (offset),
      .span   (span),
      .mag    (gmag[GB-1:0]),
      .rsp    (ramp_rsp)
   );

   // gain and saturation
   always_comb begin
      qext    = zspan_ff ? '0 : {1'b0, ramp_rsp.quot};
      gsum    = {start_gain_ff[GB-1], start_gain_ff} + (gneg_ff ? (~qext + (GB+1)'(1)) : qext);
      scaled  = prod_ff[PROD_BITS-1:lse_pkg::GAIN_FRAC];
      scaled_top = scaled[SAMPLE_BITS+1:SAMPLE_BITS-1];
      if (scaled_top == 3'b000 || scaled_top == 3'b111) begin
         sat_val = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[SAMPLE_BITS+1]) begin
         sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      age_in        = age_ff;
      sample_in     = sample_ff;
      alive_in      = alive_ff;
      ramp_in       = ramp_ff;
      gneg_in       = gneg_ff;
      zspan_in      = zspan_ff;
      gain_in       = gain_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_alive_in  = rsp_alive_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = req_sample_in;
               alive_in  = !dead;
               ramp_in   = in_ramp;
               gneg_in   = gdiff[GB];
               zspan_in  = (span == '0);
               age_in    = dead ? age_eff : (age_eff + (TIME_BITS+1)'(1));
               state_in  = in_ramp ? S_RAMP : S_EMIT;
            end
         end
         S_RAMP: begin
            if (ramp_rsp.done) begin
               gain_in  = gsum[GB-1:0];
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            prod_in  = {{GB{sample_ff[SAMPLE_BITS-1]}}, sample_ff}
                       * {{SAMPLE_BITS{gain_ff[GB-1]}}, gain_ff};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = ramp_ff ? sat_val : '0;
               rsp_alive_in  = alive_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= TIME_BITS'(lse_pkg::START_TIME_RESET);
         end_time_ff   <= TIME_BITS'(lse_pkg::END_TIME_RESET);
         start_gain_ff <= lse_pkg::START_GAIN_RESET;
         end_gain_ff   <= lse_pkg::END_GAIN_RESET;
         state_ff      <= S_IDLE;
         age_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_time_ff <= start_time_in;
         end_time_ff   <= end_time_in;
         start_gain_ff <= start_gain_in;
         end_gain_ff   <= end_gain_in;
         state_ff      <= state_in;
         age_ff        <= age_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      alive_ff      <= alive_in;
      ramp_ff       <= ramp_in;
      gneg_ff       <= gneg_in;
      zspan_ff      <= zspan_in;
      gain_ff       <= gain_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_alive_ff  <= rsp_alive_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_alive      = rsp_alive_ff;

endmodule

// ----- hw/rtl/lse_chk.sv -----
// ----------------------------------------------------------------------------
// lse_chk: port-level checks of the linear segment envelope
// Watches the top level's channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lse_chk #(
   parameter int TIME_BITS   = lse_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = lse_pkg::SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_alive
);

   // one tick in flight: a transfer in blocks the next one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("lse_chk: input taken while a tick is in flight");

   // a silent, finished envelope outputs zero
   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_alive) |-> (rsp_sample_out == '0))
      else $error("lse_chk: nonzero sample with alive low");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_sample_out) && $stable(rsp_alive)))
      else $error("lse_chk: stalled result changed");

   // reset leaves both channels quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("lse_chk: channels not idle after reset");

endmodule

bind linear_segment_envelope lse_chk #(
   .TIME_BITS   (TIME_BITS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_lse_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_alive      (rsp_alive)
);
